FILE: rtl/ialu_pkg.sv
// Shared types and constants for the integer ALU.
package ialu_pkg;

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_IMUL   = 4'd3,
        OP_DIV    = 4'd4,
        OP_REM    = 4'd5,
        OP_IDIV   = 4'd6,
        OP_IREM   = 4'd7,
        OP_MULHI  = 4'd8,
        OP_IMULHI = 4'd9,
        OP_SHL    = 4'd10,
        OP_SHR    = 4'd11,
        OP_SAR    = 4'd12,
        OP_AND    = 4'd13,
        OP_OR     = 4'd14,
        OP_XOR    = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_DIV_OVF  = 2'd2,
        ST_SHIFT    = 2'd3
    } status_t;

    localparam int unsigned XLEN     = 64;
    localparam int unsigned HLEN     = 32;
    localparam int unsigned DIV_STEPS = XLEN;
    // accept edge to the edge at which the result beat is taken
    localparam int unsigned PIPE_LAT = DIV_STEPS + 3;

endpackage

FILE: rtl/integer_alu_with_fold_checks.sv
// Pipelined 32/64-bit integer ALU with multiply, divide and shift checks.
//
//   channel  | handshake        | payload
//   ---------+------------------+-------------------------------------
//   command  | start / busy     | action, operand_a, operand_b, wide
//   result   | done (strobe)    | result, status
//
// One command beat is taken every cycle; busy stays low. Every operation passes
// through the same stages from the accept edge to the result edge, set by the
// 64-step restoring divider, one quotient bit per stage. The multiplier runs
// alongside the first divider stages. Reset clears all valid bits and drops
// items in flight. Results are shown for one cycle and are never held.
module integer_alu_with_fold_checks
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [3:0]                 action,
    input  logic [63:0]                operand_a,
    input  logic [63:0]                operand_b,
    input  logic                       wide,
    output logic                       done,
    output logic [63:0]                result,
    output ialu_pkg::status_t          status
);
    import ialu_pkg::*;

    // stage 1: cut operands
    logic        s1_v_reg;
    op_t         s1_op_reg;
    logic        s1_wide_reg;
    logic [63:0] s1_a_reg;
    logic [63:0] s1_b_reg;
    logic [63:0] in_mask;

    assign busy    = 1'b0;
    assign in_mask = wide ? {64{1'b1}} : {32'd0, {32{1'b1}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg   <= op_t'(action);
        s1_wide_reg <= wide;
        s1_a_reg    <= operand_a & in_mask;
        s1_b_reg    <= operand_b & in_mask;
    end

    // stage 2: status, simple ops, magnitudes, partial products
    logic [63:0] sa, sb, ma, mb, simple_res, lowest, wmask;
    logic        na, nb, signed_div, is_div, long_shift;
    logic [5:0]  sh;
    status_t     st;

    always_comb
    begin
        wmask  = s1_wide_reg ? {64{1'b1}} : {32'd0, {32{1'b1}}};
        sa     = s1_wide_reg ? s1_a_reg : {{32{s1_a_reg[31]}}, s1_a_reg[31:0]};
        sb     = s1_wide_reg ? s1_b_reg : {{32{s1_b_reg[31]}}, s1_b_reg[31:0]};
        na     = sa[63];
        nb     = sb[63];
        lowest = s1_wide_reg ? {1'b1, 63'd0} : {32'd0, 1'b1, 31'd0};
        signed_div = (s1_op_reg == OP_IDIV) || (s1_op_reg == OP_IREM);
        is_div = (s1_op_reg == OP_DIV) || (s1_op_reg == OP_REM) || signed_div;
        long_shift = s1_wide_reg ? (s1_b_reg[63:6] != 58'd0)
                                 : (s1_b_reg[63:5] != 59'd0);
        sh = s1_wide_reg ? s1_b_reg[5:0] : {1'b0, s1_b_reg[4:0]};
        ma = (signed_div && na) ? (64'd0 - sa) : s1_a_reg;
        mb = (signed_div && nb) ? (64'd0 - sb) : s1_b_reg;

        st = ST_OK;
        if (is_div && s1_b_reg == 64'd0)
        begin
            st = ST_DIV_ZERO;
        end
        else if (signed_div && s1_a_reg == lowest && s1_b_reg == wmask)
        begin
            st = ST_DIV_OVF;
        end
        else if ((s1_op_reg == OP_SHL || s1_op_reg == OP_SHR || s1_op_reg == OP_SAR)
                 && long_shift)
        begin
            st = ST_SHIFT;
        end

        case (s1_op_reg)
            OP_ADD:  simple_res = s1_a_reg + s1_b_reg;
            OP_SUB:  simple_res = s1_a_reg - s1_b_reg;
            OP_SHL:  simple_res = s1_a_reg << sh;
            OP_SHR:  simple_res = s1_a_reg >> sh;
            OP_SAR:  simple_res = 64'($signed(sa) >>> sh);
            OP_AND:  simple_res = s1_a_reg & s1_b_reg;
            OP_OR:   simple_res = s1_a_reg | s1_b_reg;
            OP_XOR:  simple_res = s1_a_reg ^ s1_b_reg;
            default: simple_res = 64'd0;
        endcase
    end

    // divider pipeline plus sidecar; index 0 is the stage 2 register
    logic [63:0] dv_rem_reg [0:DIV_STEPS];
    logic [63:0] dv_quo_reg [0:DIV_STEPS];
    logic [63:0] dv_den_reg [0:DIV_STEPS];
    logic        sc_v_reg   [0:DIV_STEPS];
    op_t         sc_op_reg  [0:DIV_STEPS];
    logic        sc_wide_reg[0:DIV_STEPS];
    status_t     sc_st_reg  [0:DIV_STEPS];
    logic        sc_na_reg  [0:DIV_STEPS];
    logic        sc_nb_reg  [0:DIV_STEPS];
    logic [63:0] sc_res_reg [0:DIV_STEPS];

    // multiplier stages
    logic [63:0] mp_ll_reg, mp_lh_reg, mp_hl_reg, mp_hh_reg, mp_a0_reg, mp_b0_reg;
    logic [64:0] mp_mid_reg;
    logic [63:0] mp_ll1_reg, mp_hh1_reg, mp_a1_reg, mp_b1_reg;
    logic [127:0] mp_prod_reg;
    logic [63:0]  mp_a2_reg, mp_b2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_v_reg[0] <= 1'b0;
        end
        else
        begin
            sc_v_reg[0] <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_rem_reg[0]  <= 64'd0;
        dv_quo_reg[0]  <= ma;
        dv_den_reg[0]  <= mb;
        sc_op_reg[0]   <= s1_op_reg;
        sc_wide_reg[0] <= s1_wide_reg;
        sc_st_reg[0]   <= st;
        sc_na_reg[0]   <= na;
        sc_nb_reg[0]   <= nb;
        sc_res_reg[0]  <= simple_res;
        mp_ll_reg <= 64'(s1_a_reg[31:0])  * 64'(s1_b_reg[31:0]);
        mp_lh_reg <= 64'(s1_a_reg[31:0])  * 64'(s1_b_reg[63:32]);
        mp_hl_reg <= 64'(s1_a_reg[63:32]) * 64'(s1_b_reg[31:0]);
        mp_hh_reg <= 64'(s1_a_reg[63:32]) * 64'(s1_b_reg[63:32]);
        mp_a0_reg <= s1_a_reg;
        mp_b0_reg <= s1_b_reg;
        // second multiplier stage
        mp_mid_reg <= {1'b0, mp_lh_reg} + {1'b0, mp_hl_reg};
        mp_ll1_reg <= mp_ll_reg;
        mp_hh1_reg <= mp_hh_reg;
        mp_a1_reg  <= mp_a0_reg;
        mp_b1_reg  <= mp_b0_reg;
        // third multiplier stage
        mp_prod_reg <= {mp_hh1_reg, mp_ll1_reg} + {31'd0, mp_mid_reg, 32'd0};
        mp_a2_reg   <= mp_a1_reg;
        mp_b2_reg   <= mp_b1_reg;
    end

    // multiply result picked at sidecar index 2 -> 3
    logic [63:0] hi_u, hi_s, mul_res;
    op_t         op2;

    always_comb
    begin
        op2  = sc_op_reg[2];
        hi_u = sc_wide_reg[2] ? mp_prod_reg[127:64] : {32'd0, mp_prod_reg[63:32]};
        hi_s = hi_u - (sc_na_reg[2] ? mp_b2_reg : 64'd0)
                    - (sc_nb_reg[2] ? mp_a2_reg : 64'd0);
        case (op2)
            OP_MUL, OP_IMUL: mul_res = mp_prod_reg[63:0];
            OP_MULHI:        mul_res = hi_u;
            OP_IMULHI:       mul_res = hi_s;
            default:         mul_res = sc_res_reg[2];
        endcase
    end

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_div
            logic [64:0] trial, diff;
            logic        take;

            assign trial = {dv_rem_reg[k], dv_quo_reg[k][63]};
            assign diff  = trial - {1'b0, dv_den_reg[k]};
            assign take  = trial >= {1'b0, dv_den_reg[k]};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sc_v_reg[k+1] <= 1'b0;
                end
                else
                begin
                    sc_v_reg[k+1] <= sc_v_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                dv_rem_reg[k+1]  <= take ? diff[63:0] : trial[63:0];
                dv_quo_reg[k+1]  <= {dv_quo_reg[k][62:0], take};
                dv_den_reg[k+1]  <= dv_den_reg[k];
                sc_op_reg[k+1]   <= sc_op_reg[k];
                sc_wide_reg[k+1] <= sc_wide_reg[k];
                sc_st_reg[k+1]   <= sc_st_reg[k];
                sc_na_reg[k+1]   <= sc_na_reg[k];
                sc_nb_reg[k+1]   <= sc_nb_reg[k];
                if (k == 2)
                begin
                    sc_res_reg[k+1] <= mul_res;
                end
                else
                begin
                    sc_res_reg[k+1] <= sc_res_reg[k];
                end
            end
        end
    endgenerate

    // output stage: fix divide signs, apply status and mask
    logic        done_reg;
    logic [63:0] result_reg, fin_res, out_mask, quo, rmd;
    status_t     status_reg;

    always_comb
    begin
        quo      = dv_quo_reg[DIV_STEPS];
        rmd      = dv_rem_reg[DIV_STEPS];
        out_mask = sc_wide_reg[DIV_STEPS] ? {64{1'b1}} : {32'd0, {32{1'b1}}};
        case (sc_op_reg[DIV_STEPS])
            OP_DIV:  fin_res = quo;
            OP_REM:  fin_res = rmd;
            OP_IDIV: fin_res = (sc_na_reg[DIV_STEPS] != sc_nb_reg[DIV_STEPS])
                               ? (64'd0 - quo) : quo;
            OP_IREM: fin_res = sc_na_reg[DIV_STEPS] ? (64'd0 - rmd) : rmd;
            default: fin_res = sc_res_reg[DIV_STEPS];
        endcase
        if (sc_st_reg[DIV_STEPS] != ST_OK)
        begin
            fin_res = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sc_v_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= fin_res & out_mask;
        status_reg <= sc_st_reg[DIV_STEPS];
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign status = status_reg;

endmodule

FILE: rtl/ialu_checker.sv
// Port-level checks for the integer ALU and their binding.
module ialu_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [63:0]         result,
    input ialu_pkg::status_t   status
);
    import ialu_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> result == 64'd0)
        else $error("nonzero result with fault status");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result beat without matching command");

endmodule

bind integer_alu_with_fold_checks ialu_checker u_ialu_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result),
    .status (status)
);
